[rtl/core/mk_pkg.sv]
// Morse keyer package: queue sizing, entry, write, item and result types, Morse pattern ROM.
// No dependencies; imported by mk_engine and morse_keyer.
package mk_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned QW          = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_SPACE  = 8'd32;
  localparam logic [5:0] SYM_BLANK   = 6'd36;
  localparam logic [5:0] SYM_INVALID = 6'd37;

  // one queue entry: character plus "a space follows" flag
  typedef struct packed {
    logic       space_after;
    logic [7:0] chr;
  } q_entry_t;

  localparam int unsigned ENTRY_W = $bits(q_entry_t);

  typedef struct packed {
    logic          en;
    logic [QW-1:0] addr;
    q_entry_t      data;
  } q_wr_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] character;
    logic       last_of_message;
  } item_t;

  typedef struct packed {
    logic       led_on;
    logic       accepted;
    logic [5:0] queue_count;
    logic       busy_res;
  } result_t;

  // dot = 10, dash = 110, MSB first; blank keys nothing, invalid is never loaded
  localparam logic [15:0] MORSE_ROM [38] = '{
    16'hDB6C, 16'hB6D8, 16'hADB0, 16'hAB60, 16'hAAC0,
    16'hAA80, 16'hD540, 16'hDAA0, 16'hDB50, 16'hDB68,
    16'hB000, 16'hD500, 16'hD680, 16'hD400, 16'h8000,
    16'hAD00, 16'hDA00, 16'hAA00, 16'hA000, 16'hB6C0,
    16'hD600, 16'hB500, 16'hD800, 16'hD000, 16'hDB00,
    16'hB680, 16'hDAC0, 16'hB400, 16'hA800, 16'hC000,
    16'hAC00, 16'hAB00, 16'hB600, 16'hD580, 16'hD6C0,
    16'hDA80, 16'h0001, 16'hFFFF
  };

  function automatic logic [5:0] sym_index(logic [7:0] c);
    logic [7:0] diff;
    logic [5:0] idx;
    diff = 8'd0;
    idx  = SYM_INVALID;
    if (c >= 8'd48 && c <= 8'd57) begin
      diff = c - 8'd48;
      idx  = diff[5:0];
    end else if (c >= 8'd65 && c <= 8'd90) begin
      diff = c - 8'd55;
      idx  = diff[5:0];
    end else if (c >= 8'd97 && c <= 8'd122) begin
      diff = c - 8'd87;
      idx  = diff[5:0];
    end else if (c == CHAR_SPACE) begin
      idx = SYM_BLANK;
    end
    return idx;
  endfunction

  function automatic logic [QW-1:0] next_ptr(logic [QW-1:0] p);
    logic [QW-1:0] n;
    if (p == QW'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

endpackage

[rtl/core/mk_in_if.sv]
// Input channel of the Morse keyer: valid/ready plus one item.
// No dependencies.
interface mk_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] character;
  logic       last_of_message;

  modport source (output valid, output operation, output character,
                  output last_of_message, input ready);
  modport sink   (input valid, input operation, input character,
                  input last_of_message, output ready);
endinterface

[rtl/core/mk_out_if.sv]
// Result channel of the Morse keyer: valid/ready plus one result item.
// No dependencies.
interface mk_out_if;
  logic       valid;
  logic       ready;
  logic       led_on;
  logic       accepted;
  logic [5:0] queue_count;
  logic       busy_res;

  modport source (output valid, output led_on, output accepted,
                  output queue_count, output busy_res, input ready);
  modport sink   (input valid, input led_on, input accepted,
                  input queue_count, input busy_res, output ready);
endinterface

[rtl/core/mk_char_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mk_char_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/core/mk_engine.sv]
// Keyer engine: queue pointers, fill count, pending space and the element sequencer.
// Depends on mk_pkg; drives the character RAM through a write struct and read address.
module mk_engine import mk_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  item_t         item_i,
  input  q_entry_t      rd_data_i,
  output logic [QW-1:0] rd_addr_o,
  output q_wr_t         wr_o,
  output result_t       res_o
);

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_PROC = 2'd1,
    SEQ_DASH = 2'd2,
    SEQ_DOT  = 2'd3
  } seq_e;

  seq_e          state_q, state_d;
  logic [15:0]   pat_q, pat_d;
  logic [1:0]    hold_q, hold_d;
  logic          led_q, led_d;
  logic [QW-1:0] head_q, head_d;
  logic [QW-1:0] tail_q, tail_d;
  logic [QW-1:0] fill_q, fill_d;
  logic          pend_q, pend_d;
  logic          byp_q;
  q_entry_t      byp_data_q;

  q_entry_t      head_ent;
  logic [7:0]    pop_chr;
  logic [5:0]    pop_idx;
  logic [QW:0]   room_chk;
  logic          accepted;
  logic [QW+5:0] cnt_ext;

  // RAM read of the same cycle's write is stale: forward it
  assign head_ent = byp_q ? byp_data_q : rd_data_i;
  assign pop_chr  = pend_q ? CHAR_SPACE : head_ent.chr;
  assign pop_idx  = sym_index(pop_chr);
  assign room_chk = {1'b0, fill_q} + (QW+1)'(2);

  always_comb begin
    state_d  = state_q;
    pat_d    = pat_q;
    hold_d   = hold_q;
    led_d    = led_q;
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    pend_d   = pend_q;
    accepted = 1'b0;
    wr_o     = '0;
    if (fire_i) begin
      if (item_i.operation) begin
        if (room_chk < (QW+1)'(QUEUE_DEPTH)) begin
          accepted              = 1'b1;
          wr_o.en               = 1'b1;
          wr_o.addr             = tail_q;
          wr_o.data.chr         = item_i.character;
          wr_o.data.space_after = item_i.last_of_message;
          tail_d                = next_ptr(tail_q);
          fill_d                = fill_q + QW'(1) + QW'(item_i.last_of_message);
        end
      end else begin
        unique case (state_q)
          SEQ_IDLE: begin
            if (fill_q != '0) begin
              fill_d = fill_q - 1'b1;
              if (pend_q) begin
                pend_d = 1'b0;
              end else begin
                head_d = next_ptr(head_q);
                pend_d = head_ent.space_after;
              end
              if (pop_idx != SYM_INVALID) begin
                pat_d   = MORSE_ROM[pop_idx];
                state_d = SEQ_PROC;
              end
            end
          end
          SEQ_PROC: begin
            if (pat_q[15:14] == 2'b11) begin
              pat_d   = {pat_q[12:0], 3'b000};
              hold_d  = 2'd2;
              state_d = SEQ_DASH;
              led_d   = 1'b1;
            end else if (pat_q[15]) begin
              pat_d   = {pat_q[13:0], 2'b00};
              state_d = SEQ_DOT;
              led_d   = 1'b1;
            end else begin
              state_d = SEQ_IDLE;
            end
          end
          SEQ_DASH: begin
            if (hold_q != 2'd0) begin
              hold_d = hold_q - 1'b1;
            end else begin
              state_d = SEQ_PROC;
              led_d   = 1'b0;
            end
          end
          SEQ_DOT: begin
            state_d = SEQ_PROC;
            led_d   = 1'b0;
          end
          default: begin
            state_d = SEQ_IDLE;
          end
        endcase
      end
    end
  end

  // read ahead at the head the next item will see
  assign rd_addr_o = head_d;

  assign cnt_ext           = {6'd0, fill_d};
  assign res_o.led_on      = led_d;
  assign res_o.accepted    = accepted;
  assign res_o.queue_count = cnt_ext[5:0];
  assign res_o.busy_res    = (state_d != SEQ_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      pat_q   <= '0;
      hold_q  <= '0;
      led_q   <= 1'b0;
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
      pend_q  <= 1'b0;
      byp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pat_q   <= pat_d;
      hold_q  <= hold_d;
      led_q   <= led_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      pend_q  <= pend_d;
      byp_q   <= wr_o.en && (wr_o.addr == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wr_o.data;
  end

endmodule

[rtl/core/morse_keyer.sv]
// Morse keyer top level. A result item passes from the execute register to the output
// register after its item is accepted. Throughput: one item per cycle while results
// are taken, set by the read-modify-write of the character RAM and sequencer; a result
// left waiting holds the execute stage, which then holds off the input.
// Reset (rst_ni low, asynchronous): queue empty, sequencer idle, LED off, both
// channels empty. The character RAM is not cleared; only written entries are read.
module morse_keyer import mk_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  mk_in_if.sink    in_i,
  mk_out_if.source out_o
);

  // Pipeline:
  //   accept  - item captured into the execute register
  //   execute - engine applies the item to queue and sequencer state, with the
  //             RAM entry at the current head already read (address issued in the
  //             previous cycle from the engine's next head)
  //   output  - result held until the sink takes it
  // The execute stage moves on whenever the output register is free or being
  // drained; while a result waits unclaimed it holds, and the input stalls behind it.

  logic          s2_valid_q;
  item_t         s2_item_q;
  logic          s2_adv;

  logic          out_valid_q;
  result_t       out_q;

  logic [QW-1:0] rd_addr;
  q_entry_t      rd_data;
  q_wr_t         wr;
  result_t       res;

  assign s2_adv     = s2_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s2_valid_q || s2_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s2_valid_q <= in_i.valid;
      end
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s2_item_q.operation       <= in_i.operation;
      s2_item_q.character       <= in_i.character;
      s2_item_q.last_of_message <= in_i.last_of_message;
    end
    if (s2_adv) begin
      out_q <= res;
    end
  end

  // character queue store: one entry per pushed character, flag for trailing space
  mk_char_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  mk_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s2_adv),
    .item_i    (s2_item_q),
    .rd_data_i (rd_data),
    .rd_addr_o (rd_addr),
    .wr_o      (wr),
    .res_o     (res)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.led_on      = out_q.led_on;
  assign out_o.accepted    = out_q.accepted;
  assign out_o.queue_count = out_q.queue_count;
  assign out_o.busy_res    = out_q.busy_res;

endmodule
